// ===== src/esc_telemetry_frame_receiver_defines.svh =====
// Assertion macros used by the frame window of the telemetry receiver.
`ifndef ESC_TELEMETRY_FRAME_RECEIVER_DEFINES_SVH
`define ESC_TELEMETRY_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ESC_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ESC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/esc_tfr_pkg.sv =====
// Shared types and constants of the telemetry receiver.
`timescale 1ns / 1ps

package esc_tfr_pkg;

  // Frame geometry: nine data bytes followed by one check byte.
  localparam int FRAME_BYTES = 10;
  localparam int HELD_BYTES  = FRAME_BYTES - 1;
  localparam int FILL_W      = $clog2(HELD_BYTES + 1);

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_TOP   = 8'h80;
  localparam logic [7:0] IDLE_FILL = 8'hFF;

  // Decoded frame; the first field sits in the highest bits when flattened.
  typedef struct packed {
    logic [15:0] erpm_hundreds;
    logic [15:0] consumption;
    logic [15:0] current;
    logic [15:0] voltage;
    logic [7:0]  temperature;
  } telem_t;

  localparam int DATA_W = $bits(telem_t);

endpackage

// ===== src/esc_tfr_in_stage.sv =====
// Input register: holds one received byte until the frame logic takes it.
`timescale 1ns / 1ps

module esc_tfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  logic in_valid_next;
  logic load;

  // A new beat is taken when the register is empty or drains this cycle.
  assign s_tready = !in_valid || advance;
  assign load     = s_tvalid && s_tready;

  always_comb begin
    in_valid_next = in_valid;
    if (load) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      in_byte <= s_tdata;
    end
  end

endmodule

// ===== src/esc_tfr_window.sv =====
// Frame window: collects bytes, checks the CRC-8 and decodes a good frame.
`timescale 1ns / 1ps

`include "esc_telemetry_frame_receiver_defines.svh"

module esc_tfr_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output logic                 emit,
  output esc_tfr_pkg::telem_t  telem
);

  localparam logic [esc_tfr_pkg::FILL_W-1:0] HELD_CNT =
    esc_tfr_pkg::FILL_W'(esc_tfr_pkg::HELD_BYTES);

  logic [7:0]                    window      [esc_tfr_pkg::HELD_BYTES];
  logic [7:0]                    window_next [esc_tfr_pkg::HELD_BYTES];
  logic [esc_tfr_pkg::FILL_W-1:0] fill_count;
  logic [esc_tfr_pkg::FILL_W-1:0] fill_count_next;
  logic [7:0]                    crc;
  logic                          full;
  logic                          idle_byte;
  logic                          match;
  logic                          store;

  // CRC of the held bytes, MSB first. Each shift step XORs in a fixed polynomial
  // when the top bit is set, so the unrolled loop is a fixed XOR network of the window bits.
  always_comb begin
    crc = 8'h00;
    for (int i = 0; i < esc_tfr_pkg::HELD_BYTES; i++) begin
      crc = crc ^ window[i];
      for (int k = 0; k < 8; k++) begin
        crc = {crc[6:0], 1'b0} ^ (crc[7] ? esc_tfr_pkg::CRC_POLY : 8'h00);
      end
    end
  end

  assign full      = fill_count >= HELD_CNT;
  assign idle_byte = (fill_count == '0) && (rx_byte == esc_tfr_pkg::IDLE_FILL);
  assign match     = full && (crc == rx_byte);
  assign emit      = step && match;
  assign store     = step && !idle_byte && !full;

  // Next window contents and fill count.
  always_comb begin
    window_next     = window;
    fill_count_next = fill_count;
    if (step && !idle_byte) begin
      if (!full) begin
        for (int i = 0; i < esc_tfr_pkg::HELD_BYTES; i++) begin
          if (fill_count == esc_tfr_pkg::FILL_W'(i)) begin
            window_next[i] = rx_byte;
          end
        end
        fill_count_next = fill_count + 1'b1;
      end else if (match) begin
        fill_count_next = '0;
      end else begin
        // Bad check byte: slide by one and keep it as the newest byte.
        for (int i = 0; i < esc_tfr_pkg::HELD_BYTES - 1; i++) begin
          window_next[i] = window[i+1];
        end
        window_next[esc_tfr_pkg::HELD_BYTES-1] = rx_byte;
        fill_count_next = HELD_CNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  // Window bytes hold data only and are never cleared.
  always_ff @(posedge clk) begin
    window <= window_next;
  end

  // Big-endian word decode of the held frame.
  always_comb begin
    telem.temperature   = window[0];
    telem.voltage       = {window[1], window[2]};
    telem.current       = {window[3], window[4]};
    telem.consumption   = {window[5], window[6]};
    telem.erpm_hundreds = {window[7], window[8]};
  end

  `ESC_ASSERT_IMPL(a_fill_in_range, 1'b1, fill_count <= HELD_CNT, "fill count beyond window")
  `ESC_ASSERT_NEXT(a_emit_clears, emit, fill_count == '0, "window not emptied after a frame")
  `ESC_ASSERT_NEXT(a_idle_skipped, step && idle_byte, fill_count == '0, "idle fill was stored")
  `ESC_ASSERT_NEXT(a_fill_grows, store, fill_count == $past(fill_count) + 1'b1, "byte not stored")

endmodule

// ===== src/esc_tfr_out_stage.sv =====
// Output register: holds one decoded frame until the downstream side takes it.
`timescale 1ns / 1ps

module esc_tfr_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  esc_tfr_pkg::telem_t            telem,
  output logic                           space,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [esc_tfr_pkg::DATA_W-1:0] m_tdata
);

  logic m_tvalid_next;

  // Room for a new frame when empty or when the held beat leaves now.
  assign space = !m_tvalid || m_tready;

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= telem;
    end
  end

endmodule

// ===== src/esc_telemetry_frame_receiver.sv =====
// ESC telemetry receiver: input stage, frame window with CRC check, output stage.
//
// Usage: feed received telemetry bytes, one per beat, on the s_ channel.
// Idle fill bytes (0xFF) are skipped while no byte is held. After nine held
// bytes, the next byte is the check byte: when the CRC-8 (poly 0x07, start 0)
// of the nine bytes matches it, one decoded frame beat is sent on the m_
// channel and the window empties; otherwise the window slides by one byte.
// Path: input register, window check, output register.
// Throughput: one byte per cycle while the output register has room; the CRC
// is a fixed XOR network over the held bytes, so the window can update every cycle.
// The input register lets one byte be accepted while a frame waits on m_.
// When the receiver stalls with a frame held, the input register fills and
// s_tready drops until the frame is taken.
// Reset clears both stage valid flags and the fill count; the window bytes
// keep whatever they held and are rewritten before use.
// m_tdata fields from bit 0: temperature[7:0], voltage[23:8],
// current[39:24], consumption[55:40], erpm_hundreds[71:56].
`timescale 1ns / 1ps

module esc_telemetry_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] temperature, [23:8] voltage, [39:24] current,
  // [55:40] consumption, [71:56] erpm_hundreds
  output logic [esc_tfr_pkg::DATA_W-1:0] m_tdata
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                advance;
  logic                space;
  logic                emit;
  esc_tfr_pkg::telem_t telem;

  // A held byte is processed whenever the output register can take a frame.
  assign advance = in_valid && space;

  esc_tfr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  esc_tfr_window u_window (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .emit    (emit),
    .telem   (telem)
  );

  esc_tfr_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (emit),
    .telem    (telem),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== dv/esc_telemetry_frame_receiver_tb.sv =====
// Self-checking testbench for the ESC telemetry frame receiver.
`timescale 1ns / 1ps

module esc_telemetry_frame_receiver_tb;

  localparam int WIN_W = 8 * esc_tfr_pkg::HELD_BYTES;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;   // [7:0] rx_byte
  logic                           m_tvalid;
  logic                           m_tready;
  // [7:0] temperature, [23:8] voltage, [39:24] current,
  // [55:40] consumption, [71:56] erpm_hundreds
  logic [esc_tfr_pkg::DATA_W-1:0] m_tdata;

  esc_telemetry_frame_receiver u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Bytes waiting to be sent and decoded frames waiting to come out.
  logic [7:0]          tx_bytes[$];
  esc_tfr_pkg::telem_t expected_frames[$];

  // Shadow of the receiver window; byte i of the window sits at [8*i +: 8].
  logic [WIN_W-1:0] held;
  int               held_count;

  int  error_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  recv_hold;
  bit  in_fire;

  // CRC-8, polynomial 0x07, start value zero, MSB first, over the window.
  function automatic logic [7:0] crc8_bytes(input logic [WIN_W-1:0] win);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < esc_tfr_pkg::HELD_BYTES; i++) begin
      acc = acc ^ win[8*i +: 8];
      for (int k = 0; k < 8; k++) begin
        if ((acc & esc_tfr_pkg::CRC_TOP) != 8'h00) begin
          acc = 8'(acc << 1) ^ esc_tfr_pkg::CRC_POLY;
        end else begin
          acc = 8'(acc << 1);
        end
      end
    end
    return acc;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Follows the window for one accepted byte and queues any decoded frame.
  task automatic track_rx_byte(input logic [7:0] b);
    esc_tfr_pkg::telem_t f;
    if (held_count == 0 && b == esc_tfr_pkg::IDLE_FILL) begin
      // Idle fill between frames leaves the state alone.
    end else if (held_count < esc_tfr_pkg::HELD_BYTES) begin
      held[8*held_count +: 8] = b;
      held_count++;
    end else if (crc8_bytes(held) == b) begin
      f.temperature   = held[7:0];
      f.voltage       = {held[15:8], held[23:16]};
      f.current       = {held[31:24], held[39:32]};
      f.consumption   = {held[47:40], held[55:48]};
      f.erpm_hundreds = {held[63:56], held[71:64]};
      expected_frames.push_back(f);
      held_count = 0;
    end else begin
      // Bad check byte: drop the oldest byte and keep the check byte.
      held = {b, held[WIN_W-1:8]};
    end
  endtask

  // Random byte leaning toward the extremes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 8'h00;
    end else if (r < 20) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  // Queues nine data bytes and a check byte with the given bits flipped.
  task automatic push_frame(input logic [WIN_W-1:0] d, input logic [7:0] flip);
    for (int i = 0; i < esc_tfr_pkg::HELD_BYTES; i++) begin
      tx_bytes.push_back(d[8*i +: 8]);
    end
    tx_bytes.push_back(crc8_bytes(d) ^ flip);
  endtask

  // Mostly good frames, some broken ones, idle fill and line noise.
  task automatic gen_traffic(input int n);
    logic [WIN_W-1:0] d;
    int               sent;
    int               r;
    int               len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      for (int i = 0; i < esc_tfr_pkg::HELD_BYTES; i++) begin
        d[8*i +: 8] = pick_byte();
      end
      if (r < 65) begin
        push_frame(d, 8'h00);
        sent += esc_tfr_pkg::FRAME_BYTES;
      end else if (r < 75) begin
        push_frame(d, 8'(1 << $urandom_range(7)));
        sent += esc_tfr_pkg::FRAME_BYTES;
      end else if (r < 82) begin
        // Truncated frame.
        len = $urandom_range(1, esc_tfr_pkg::HELD_BYTES);
        for (int i = 0; i < len; i++) begin
          tx_bytes.push_back(d[8*i +: 8]);
        end
        sent += len;
      end else if (r < 92) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          tx_bytes.push_back(esc_tfr_pkg::IDLE_FILL);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          tx_bytes.push_back(8'($urandom_range(255)));
        end
        sent += len;
      end
    end
  endtask

  // Waits until every queued byte is taken and every frame has come out.
  task automatic wait_drained();
    while (tx_bytes.size() != 0 || s_tvalid) begin
      @(posedge clk);
    end
    while (expected_frames.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever begin
      #1 clk = ~clk;
    end
  end

  // Input driver: offers the next byte once the current beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
    end else if (!s_tvalid || in_fire) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= tx_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side ready, with random stalls and long hold-offs.
  always @(negedge clk) begin
    if (rst || recv_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each output beat, then tracks each accepted input beat.
  always @(posedge clk) begin
    esc_tfr_pkg::telem_t got;
    esc_tfr_pkg::telem_t exp_f;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = esc_tfr_pkg::telem_t'(m_tdata);
        if (expected_frames.size() == 0) begin
          report_error($sformatf("unexpected frame beat %h", m_tdata));
        end else begin
          exp_f = expected_frames.pop_front();
          if (got.temperature !== exp_f.temperature) begin
            report_error($sformatf("temperature got %h want %h",
                                   got.temperature, exp_f.temperature));
          end
          if (got.voltage !== exp_f.voltage) begin
            report_error($sformatf("voltage got %h want %h",
                                   got.voltage, exp_f.voltage));
          end
          if (got.current !== exp_f.current) begin
            report_error($sformatf("current got %h want %h",
                                   got.current, exp_f.current));
          end
          if (got.consumption !== exp_f.consumption) begin
            report_error($sformatf("consumption got %h want %h",
                                   got.consumption, exp_f.consumption));
          end
          if (got.erpm_hundreds !== exp_f.erpm_hundreds) begin
            report_error($sformatf("erpm_hundreds got %h want %h",
                                   got.erpm_hundreds, exp_f.erpm_hundreds));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        track_rx_byte(s_tdata);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [WIN_W-1:0] d;
    logic [WIN_W-1:0] w;
    int               idle_pct[4];
    int               stall_pct[4];
    idle_pct  = '{0, 73, 0, 31};
    stall_pct = '{0, 0, 73, 31};
    rst            = 1'b1;
    error_count    = 0;
    held           = '0;
    held_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Idle fill before a frame, then an all-zero frame.
    tx_bytes.push_back(esc_tfr_pkg::IDLE_FILL);
    tx_bytes.push_back(esc_tfr_pkg::IDLE_FILL);
    push_frame('0, 8'h00);
    // Bad check byte, then resync: the window slides and the next byte
    // completes a frame of 0xFF bytes plus the failed check byte.
    d = {{(esc_tfr_pkg::HELD_BYTES - 1){8'hFF}}, 8'hFE};
    push_frame(d, 8'h01);
    w = {crc8_bytes(d) ^ 8'h01, {(esc_tfr_pkg::HELD_BYTES - 1){8'hFF}}};
    tx_bytes.push_back(crc8_bytes(w));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      if (p == 0) begin
        // Long receiver hold-off while bytes keep coming.
        fork
          begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      gen_traffic(445);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("esc_telemetry_frame_receiver_tb: done, clean");
    end else begin
      $display("esc_telemetry_frame_receiver_tb: done, errors");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #2000000;
    $display("esc_telemetry_frame_receiver_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/esc_tfr_pkg.sv
src/esc_tfr_in_stage.sv
src/esc_tfr_window.sv
src/esc_tfr_out_stage.sv
src/esc_telemetry_frame_receiver.sv
dv/esc_telemetry_frame_receiver_tb.sv
